[sv/plk_pkg.sv]
`default_nettype none

package plk_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = 5;
  localparam int ICNT_W   = 5;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_APPEND   = 3'd1,
    CMD_DELETE   = 3'd2,
    CMD_DEL_TAIL = 3'd3,
    CMD_READ     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   tail;
    logic signed [31:0] value;
    logic signed [31:0] head;
  } cell_ctl_t;

endpackage

`default_nettype wire

[sv/plk_cell.sv]
`default_nettype none

module plk_cell
  import plk_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic [IDX_W-1:0]   slot_i,
  input  wire cell_ctl_t          ctl_i,
  input  wire logic signed [31:0] prev_i,
  input  wire logic signed [31:0] next_i,
  output logic signed [31:0]      value_o
);

  logic signed [31:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (ctl_i.op)
      OP_INS: begin
        if (slot_i == ctl_i.idx) begin
          value_d = ctl_i.value;
        end else if (slot_i > ctl_i.idx) begin
          value_d = prev_i;
        end
      end
      OP_DEL: begin
        if (slot_i >= ctl_i.idx) begin
          value_d = next_i;
        end
      end
      OP_ROT: begin
        if (slot_i == ctl_i.tail) begin
          value_d = ctl_i.head;
        end else begin
          value_d = next_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

[sv/positional_list_insert_delete_top.sv]
// Bounded positional list of signed 32-bit values held in a chain of cells,
// one element per cell. Insert, append, delete and delete-tail leave busy
// low, and each strobes a single result on result_valid_o in the cycle
// after start, so edits may be issued every cycle. A readout of N elements
// strobes N results on consecutive cycles, the first in the cycle after
// start, while the chain rotates one place per cycle toward the head; busy
// is high while each result but the last is on the ports. An empty readout
// gives one result and does not raise busy. Results cannot be held off;
// each one is on the ports for exactly one cycle.
`default_nettype none

module positional_list_insert_delete_top
  import plk_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [2:0]          cmd_i,
  input  wire logic signed [31:0]  value_i,
  input  wire logic [POS_W-1:0]    position_i,
  output logic                     result_valid_o,
  output logic signed [31:0]       item_value_o,
  output logic [ICNT_W-1:0]        item_count_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    rd_idx_q, rd_idx_d;
  logic                valid_q, valid_d;
  logic signed [31:0]  res_value_q, res_value_d;
  status_e             res_status_q, res_status_d;
  logic                res_last_q, res_last_d;

  cell_ctl_t           ctl;
  logic signed [31:0]  cell_val [CAPACITY];
  logic                accept;
  logic [CMP_W-1:0]    pos_ext, cnt_ext;
  logic [IDX_W-1:0]    tail;

  assign accept  = start && !busy;
  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(cnt_q);
  assign tail    = IDX_W'(cnt_q - CNT_W'(1));

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_idx_d     = rd_idx_q;
    valid_d      = 1'b0;
    res_value_d  = '0;
    res_status_d = STAT_DONE;
    res_last_d   = 1'b1;
    ctl.op       = OP_HOLD;
    ctl.idx      = IDX_W'(pos_ext - CMP_W'(1));
    ctl.tail     = tail;
    ctl.value    = value_i;
    ctl.head     = cell_val[0];

    case (state_q)
      ST_READ: begin
        ctl.op      = OP_ROT;
        valid_d     = 1'b1;
        res_value_d = cell_val[0];
        res_last_d  = (rd_idx_q == tail);
        rd_idx_d    = rd_idx_q + IDX_W'(1);
        if (res_last_d) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          case (cmd_i)
            CMD_INSERT: begin
              if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                res_status_d = STAT_REJECT;
              end else if (cnt_ext == CMP_W'(CAPACITY)) begin
                res_status_d = STAT_FULL;
              end else begin
                ctl.op = OP_INS;
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end
            CMD_APPEND: begin
              if (cnt_ext == CMP_W'(CAPACITY)) begin
                res_status_d = STAT_FULL;
              end else begin
                ctl.op  = OP_INS;
                ctl.idx = IDX_W'(cnt_q);
                cnt_d   = cnt_q + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                res_status_d = STAT_REJECT;
              end else begin
                ctl.op = OP_DEL;
                cnt_d  = cnt_q - CNT_W'(1);
              end
            end
            CMD_DEL_TAIL: begin
              if (cnt_q == '0) begin
                res_status_d = STAT_REJECT;
              end else begin
                cnt_d = cnt_q - CNT_W'(1);
              end
            end
            CMD_READ: begin
              if (cnt_q == '0) begin
                res_status_d = STAT_EMPTY;
              end else begin
                ctl.op      = OP_ROT;
                res_value_d = cell_val[0];
                res_last_d  = (cnt_q == CNT_W'(1));
                rd_idx_d    = IDX_W'(1);
                if (!res_last_d) begin
                  state_d = ST_READ;
                end
              end
            end
            default: res_status_d = STAT_REJECT;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] prev_val, next_val;
    if (i == 0) begin : g_first
      assign prev_val = '0;
    end else begin : g_mid
      assign prev_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign next_val = '0;
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end
    plk_cell u_cell (
      .clk_i   (clk_i),
      .slot_i  (IDX_W'(i)),
      .ctl_i   (ctl),
      .prev_i  (prev_val),
      .next_i  (next_val),
      .value_o (cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign busy           = (state_q == ST_READ);
  assign result_valid_o = valid_q;
  assign item_value_o   = res_value_q;
  assign item_count_o   = ICNT_W'(cnt_q);
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

  a_busy_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> result_valid_o)
    else $error("readout cycle without a result");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(cnt_q) <= CMP_W'(CAPACITY))
    else $error("element count above capacity");

  a_read_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !last_o)
    else $error("multi-item readout flagged last on first item");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != STAT_DONE) |-> (last_o && !busy))
    else $error("non-done status not a single final item");

endmodule

`default_nettype wire

[verif/tb_positional_list_insert_delete_top.sv]
`timescale 1ns / 100ps

module tb_positional_list_insert_delete_top;
  import plk_pkg::*;

  localparam int RANDOM_ITEMS = 172;
  localparam int CALM_ITEMS   = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic signed [31:0] value;
    logic [ICNT_W-1:0]  count;
    status_e            status;
    logic               last;
  } list_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [2:0]              cmd_i;
  logic signed [31:0]      value_i;
  logic [POS_W-1:0]        position_i;
  logic                    result_valid_o;
  logic signed [31:0]      item_value_o;
  logic [ICNT_W-1:0]       item_count_o;
  logic [1:0]              status_o;
  logic                    last_o;

  logic signed [31:0] list_vals [CAPACITY];
  int                 list_len = 0;
  list_result_t       pending_results [$];
  int                 mismatch_cnt = 0;
  int                 cycle_cnt;

  positional_list_insert_delete_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .result_valid_o (result_valid_o),
    .item_value_o   (item_value_o),
    .item_count_o   (item_count_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // applies one command to the shadow list and queues the items it yields
  function automatic void apply_list_cmd(input logic [2:0] c, input logic signed [31:0] v,
                                         input logic [POS_W-1:0] p);
    status_e      st;
    list_result_t r;
    int           k;
    int           i;
    st = STAT_DONE;
    case (c)
      CMD_INSERT, CMD_APPEND: begin
        k = (c == CMD_APPEND) ? list_len : int'(p) - 1;
        if (c == CMD_INSERT && (p == 0 || int'(p) > list_len + 1)) begin
          st = STAT_REJECT;
        end else if (list_len >= CAPACITY) begin
          st = STAT_FULL;
        end else begin
          for (i = list_len; i > k; i--) list_vals[i] = list_vals[i-1];
          list_vals[k] = v;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (p == 0 || int'(p) > list_len) begin
          st = STAT_REJECT;
        end else begin
          for (i = int'(p) - 1; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      CMD_DEL_TAIL: begin
        if (list_len == 0) st = STAT_REJECT;
        else list_len--;
      end
      CMD_READ: begin
        if (list_len == 0) begin
          st = STAT_EMPTY;
        end else begin
          for (i = 0; i < list_len; i++) begin
            r.value  = list_vals[i];
            r.count  = list_len[ICNT_W-1:0];
            r.status = STAT_DONE;
            r.last   = (i == list_len - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: begin
        st = STAT_REJECT;
      end
    endcase
    r.value  = '0;
    r.count  = list_len[ICNT_W-1:0];
    r.status = st;
    r.last   = 1'b1;
    pending_results.push_back(r);
  endfunction

  // start stays high after acceptance so back-to-back items need no extra edge
  task automatic send_item(input logic [2:0] c, input logic signed [31:0] v,
                           input logic [POS_W-1:0] p);
    start      <= 1'b1;
    cmd_i      <= c;
    value_i    <= v;
    position_i <= p;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    apply_list_cmd(c, v, p);
  endtask

  task automatic idle_for(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_list();
    send_item(CMD_READ, 32'sd0, 5'd0);
    send_item(CMD_DEL_TAIL, 32'sd0, 5'd0);
    send_item(CMD_DELETE, 32'sd0, 5'd1);
    send_item(CMD_DELETE, 32'sd0, 5'd0);
    send_item(CMD_INSERT, 32'sd5, 5'd0);
    send_item(CMD_INSERT, 32'sd5, 5'd2);
    send_item(3'd5, 32'sd1, 5'd1);
    send_item(3'd6, -32'sd1, 5'd31);
    send_item(3'd7, 32'sd0, 5'd0);
  endtask

  task automatic test_edges_and_full();
    int n;
    send_item(CMD_APPEND, 32'sh8000_0000, 5'd0);
    send_item(CMD_APPEND, 32'sh7FFF_FFFF, 5'd31);
    send_item(CMD_INSERT, -32'sd1, 5'd1);
    send_item(CMD_INSERT, 32'sd0, 5'd4);
    send_item(CMD_INSERT, 32'sh5555_5555, 5'd2);
    send_item(CMD_READ, 32'sd0, 5'd0);
    for (n = list_len; n < CAPACITY; n++) send_item(CMD_APPEND, $urandom, 5'd0);
    // full list: valid positions give full, bad positions are rejected first
    send_item(CMD_APPEND, 32'sd9, 5'd0);
    send_item(CMD_INSERT, 32'sd9, 5'd3);
    send_item(CMD_INSERT, 32'sd9, 5'd17);
    send_item(CMD_INSERT, 32'sd9, 5'd18);
    send_item(CMD_READ, 32'sd0, 5'd0);
    send_item(CMD_DELETE, 32'sd0, 5'd17);
    send_item(CMD_DELETE, 32'sd0, 5'd16);
    send_item(CMD_DELETE, 32'sd0, 5'd1);
    send_item(CMD_DELETE, 32'sd0, 5'd7);
    send_item(CMD_DEL_TAIL, 32'sd0, 5'd0);
    send_item(CMD_READ, 32'sd0, 5'd0);
  endtask

  task automatic test_random_mix();
    int                 n;
    int                 r;
    int                 hi;
    bit                 grow;
    logic [2:0]         c;
    logic [POS_W-1:0]   p;
    logic signed [31:0] v;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      grow = ((n / 35) % 2 == 1);
      r    = $urandom_range(0, 99);
      p    = POS_W'($urandom_range(0, 31));
      v    = $urandom;
      case ($urandom_range(0, 9))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7FFF_FFFF;
        default: ;
      endcase
      if (r < 5) begin
        c = 3'($urandom_range(5, 7));
      end else if (r < 18) begin
        c = CMD_READ;
      end else if (r < (grow ? 68 : 38)) begin
        c = ($urandom_range(0, 2) == 0) ? CMD_APPEND : CMD_INSERT;
        if (c == CMD_INSERT && $urandom_range(0, 6) != 0) begin
          p = POS_W'($urandom_range(1, list_len + 1));
        end
      end else begin
        c  = ($urandom_range(0, 2) == 0) ? CMD_DEL_TAIL : CMD_DELETE;
        hi = (list_len > 0) ? list_len : 1;
        if (c == CMD_DELETE && $urandom_range(0, 6) != 0) p = POS_W'($urandom_range(1, hi));
      end
      if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0) begin
        idle_for($urandom_range(1, 16));
      end
      if (n == RANDOM_ITEMS / 2) wait_drained();
      send_item(c, v, p);
    end
  endtask

  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      got.value  = item_value_o;
      got.count  = item_count_o;
      got.status = status_e'(status_o);
      got.last   = last_o;
      if (pending_results.size() == 0) begin
        if (mismatch_cnt < REPORT_MAX) begin
          $display("%0t: unexpected item value %0d count %0d status %0d last %0d",
                   $realtime, got.value, got.count, got.status, got.last);
        end
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value || got.count !== want.count ||
            got.status !== want.status || got.last !== want.last) begin
          if (mismatch_cnt < REPORT_MAX) begin
            $display("%0t: expected value %0d count %0d status %0d last %0d", $realtime,
                     want.value, want.count, want.status, want.last);
            $display("%0t: actual   value %0d count %0d status %0d last %0d", $realtime,
                     got.value, got.count, got.status, got.last);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_positional_list_insert_delete_top: done, errors");
    $finish;
  end

  initial begin
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    cmd_i      <= CMD_READ;
    value_i    <= '0;
    position_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edges_and_full();
    test_random_mix();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_positional_list_insert_delete_top: done, clean");
    end else begin
      $display("tb_positional_list_insert_delete_top: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
sv/plk_pkg.sv
sv/plk_cell.sv
sv/positional_list_insert_delete_top.sv
verif/tb_positional_list_insert_delete_top.sv
